// File: rtl/bdlp_pkg.sv
// Shared types and constants for the button debounce / long-press block.
// No dependencies.
package bdlp_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    // Opcodes carried in tuser
    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_INIT     = 2'd1;
    localparam logic [1:0] OP_RD_SHORT = 2'd2;
    localparam logic [1:0] OP_RD_LONG  = 2'd3;

    // Register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_LONG     = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] now_ms;
        logic              level;
    } t_item;

    typedef struct packed {
        logic flag_value;
        logic long_press;
        logic short_press;
        logic stable_level;
    } t_result;

endpackage

// File: rtl/bdlp_in_stage.sv
// Input register stage: holds one accepted transaction until the core takes it.
// Depends on bdlp_pkg.
module bdlp_in_stage
    import bdlp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/bdlp_core.sv
// Button state update and result register; also holds the two config registers.
// Depends on bdlp_pkg.
module bdlp_core
    import bdlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_result
);

    logic [CFG_W-1:0]  r_debounce, r_long;
    logic              r_stable, r_trans_lvl, r_long_done, r_short_sticky, r_long_sticky;
    logic [TIME_W-1:0] r_trans_start, r_prev_time, r_press_start;
    logic              r_out_valid;
    t_result           r_out;

    logic              n_stable, n_trans_lvl, n_long_done, n_short_sticky, n_long_sticky;
    logic [TIME_W-1:0] n_trans_start, n_prev_time, n_press_start;
    t_result           n_out;
    logic [TIME_W-1:0] deb_elapsed, press_elapsed;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_stable       = r_stable;
        n_trans_lvl    = r_trans_lvl;
        n_trans_start  = r_trans_start;
        n_prev_time    = r_prev_time;
        n_press_start  = r_press_start;
        n_long_done    = r_long_done;
        n_short_sticky = r_short_sticky;
        n_long_sticky  = r_long_sticky;
        n_out          = '0;
        deb_elapsed    = '0;
        press_elapsed  = '0;
        case (i_item.opcode)
            OP_UPDATE: begin
                if (i_item.level != r_trans_lvl) begin
                    n_trans_lvl   = i_item.level;
                    n_trans_start = r_prev_time;
                end
                deb_elapsed = i_item.now_ms - n_trans_start;
                if (deb_elapsed >= {{(TIME_W-CFG_W){1'b0}}, r_debounce}
                        && n_trans_lvl != r_stable) begin
                    n_stable = n_trans_lvl;
                    if (!n_stable) begin
                        n_press_start = i_item.now_ms;
                        n_long_done   = 1'b0;
                    end else if (!r_long_done) begin
                        n_short_sticky    = 1'b1;
                        n_out.short_press = 1'b1;
                    end
                end
                press_elapsed = i_item.now_ms - n_press_start;
                if (!n_stable && !n_long_done
                        && press_elapsed >= {{(TIME_W-CFG_W){1'b0}}, r_long}) begin
                    n_long_done      = 1'b1;
                    n_long_sticky    = 1'b1;
                    n_out.long_press = 1'b1;
                end
                n_prev_time = i_item.now_ms;
            end
            OP_INIT: begin
                n_stable       = i_item.level;
                n_trans_lvl    = i_item.level;
                n_trans_start  = i_item.now_ms;
                n_prev_time    = i_item.now_ms;
                n_long_done    = 1'b0;
                n_short_sticky = 1'b0;
                n_long_sticky  = 1'b0;
            end
            OP_RD_SHORT: begin
                n_out.flag_value = r_short_sticky;
                n_short_sticky   = 1'b0;
            end
            default: begin
                n_out.flag_value = r_long_sticky;
                n_long_sticky    = 1'b0;
            end
        endcase
        n_out.stable_level = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long     <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                default:      r_long     <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable       <= 1'b1;
            r_trans_lvl    <= 1'b1;
            r_trans_start  <= '0;
            r_prev_time    <= '0;
            r_press_start  <= '0;
            r_long_done    <= 1'b0;
            r_short_sticky <= 1'b0;
            r_long_sticky  <= 1'b0;
        end else if (o_take) begin
            r_stable       <= n_stable;
            r_trans_lvl    <= n_trans_lvl;
            r_trans_start  <= n_trans_start;
            r_prev_time    <= n_prev_time;
            r_press_start  <= n_press_start;
            r_long_done    <= n_long_done;
            r_short_sticky <= n_short_sticky;
            r_long_sticky  <= n_long_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    // A long press is reported only while pressed; a short press only on release.
    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.long_press) |-> !r_out.stable_level)
        else $error("long_press with released level");

    a_short_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.short_press) |-> r_out.stable_level)
        else $error("short_press with pressed level");

    a_long_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && n_out.long_press) |=> (r_long_done && r_long_sticky))
        else $error("long press fired without latching done/sticky");

    a_no_refire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_long_done && !r_stable && i_item.opcode == OP_UPDATE
            && !n_stable) |-> !n_out.long_press)
        else $error("long press fired twice for one press");

endmodule

// File: rtl/button_debounce_long_press.sv
// Top level of the button debounce / long-press qualifier.
// Depends on bdlp_pkg, bdlp_in_stage and bdlp_core.
//
// Usage:
//   Slave stream carries one operation per transaction: tuser is the opcode
//   (update, init, read-clear short flag, read-clear long flag), tdata holds
//   now_ms[31:0] and the raw active-low level in bit 32.
//   Master stream returns exactly one result per operation: bit 0 stable level,
//   bit 1 short_press, bit 2 long_press, bit 3 sticky flag value.
//   Config channel writes debounce_time (index 0) or long_press_time (index 1);
//   it is always ready and must only be used while no operation is in flight.
// Timing:
//   A transaction lands in the input register; the core takes it from there,
//   runs the state update and loads the result register.
//   Throughput is one transaction per cycle while m_axis_tready is high; the
//   limit is the state update loop (two 32-bit time subtractions and compares).
// Reset: synchronous active low; levels go to released, timers and flags clear,
//   registers return to 50 ms and 2000 ms.
// Stall: when m_axis_tready is low the result is held, the input register still
//   fills, and s_axis_tready drops only once both stages are occupied.
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Config write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // [31:0] now_ms, [32] level, [39:33] zero
    input  logic [1:0]       s_axis_tuser,   // [1:0] opcode
    // Result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] stable_level, [1] short_press,
                                             // [2] long_press, [3] flag_value, [7:4] zero
);

    t_item   in_item, stage_item;
    t_result result;
    logic    stage_valid, take;

    assign o_cfg_ready = 1'b1;

    assign in_item.opcode = s_axis_tuser;
    assign in_item.now_ms = s_axis_tdata[TIME_W-1:0];
    assign in_item.level  = s_axis_tdata[TIME_W];

    bdlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    bdlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (take),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {4'b0000, result};

endmodule
